[rtl/core/crc_pkg.sv]
`timescale 1ns / 1ps
package crc_pkg;

  localparam int unsigned MinPerDay = 1440;
  localparam int unsigned MsPerSec  = 1000;
  localparam int unsigned RawFull   = 4095;
  localparam int unsigned PctFull   = 100;

  localparam int unsigned InDataW  = 88;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned AddrW    = 5;
  localparam int unsigned DataW    = 32;

  // bit positions in mode_flags
  localparam int unsigned ModeLightOne = 0;
  localparam int unsigned ModeLightTwo = 1;
  localparam int unsigned ModeAutoFan  = 2;
  localparam int unsigned ModeAutoPump = 3;

  typedef enum logic [2:0] {
    RegFanOnTemp    = 3'd0,
    RegFanOffTemp   = 3'd1,
    RegSoilLimits   = 3'd2,
    RegPumpMinOff   = 3'd3,
    RegPumpMaxOn    = 3'd4,
    RegLightOneWin  = 3'd5,
    RegLightTwoWin  = 3'd6,
    RegModeFlags    = 3'd7
  } crc_reg_e;

  typedef struct packed {
    logic signed [14:0] fan_on_temp;
    logic signed [14:0] fan_off_temp;
    logic [14:0]        soil_limits;
    logic [22:0]        pump_min_off_sec;
    logic [22:0]        pump_max_on_sec;
    logic [21:0]        light_one_window;
    logic [21:0]        light_two_window;
    logic [3:0]         mode_flags;
  } crc_cfg_t;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic               time_valid;
    logic [10:0]        minute_of_day;
    logic               temp_valid;
    logic signed [14:0] temperature;
    logic [11:0]        soil_one_raw;
    logic [11:0]        soil_two_raw;
  } crc_item_t;

  typedef struct packed {
    logic       light_one_on;
    logic       light_two_on;
    logic       fan_on;
    logic       pump_on;
    logic [6:0] soil_one_percent;
    logic [6:0] soil_two_percent;
  } crc_result_t;

  function automatic logic [10:0] day_wrap(input logic [10:0] m);
    return (m >= 11'(MinPerDay)) ? m - 11'(MinPerDay) : m;
  endfunction

  function automatic logic window_on(input logic [21:0] win, input logic [10:0] minute);
    logic [10:0] on_m;
    logic [10:0] off_m;
    logic [10:0] now_m;
    on_m  = day_wrap(win[10:0]);
    off_m = day_wrap(win[21:11]);
    now_m = day_wrap(minute);
    if (on_m == off_m) return 1'b0;
    if (on_m < off_m) return (now_m >= on_m) && (now_m < off_m);
    return (now_m >= on_m) || (now_m < off_m);
  endfunction

  // 100 - floor(100*raw/4095): reciprocal estimate, then one correction step
  function automatic logic [6:0] soil_pct(input logic [11:0] raw);
    logic [18:0] p;
    logic [18:0] t;
    logic [6:0]  q0;
    logic [18:0] rem;
    logic [6:0]  q;
    p   = 19'(raw) * 19'(PctFull);
    t   = p + (p >> 12);
    q0  = 7'(t >> 12);
    rem = p - 19'(q0) * 19'(RawFull);
    q   = (rem >= 19'(RawFull)) ? q0 + 7'd1 : q0;
    return 7'(PctFull) - q;
  endfunction

endpackage

[rtl/core/crc_cfg_regs.sv]
`timescale 1ns / 1ps
module crc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crc_pkg::AddrW-1:0]     paddr,
  input  logic [crc_pkg::DataW-1:0]     pwdata,
  output logic [crc_pkg::DataW-1:0]     prdata,
  output crc_pkg::crc_cfg_t             cfg_o
);

  crc_pkg::crc_cfg_t cfg_q, cfg_d;
  crc_pkg::crc_reg_e reg_sel;
  logic              wr_en;

  assign reg_sel = crc_pkg::crc_reg_e'(paddr[4:2]);
  // pready is tied high, so the access phase completes the transfer
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_sel)
        crc_pkg::RegFanOnTemp:   cfg_d.fan_on_temp      = $signed(pwdata[14:0]);
        crc_pkg::RegFanOffTemp:  cfg_d.fan_off_temp     = $signed(pwdata[14:0]);
        crc_pkg::RegSoilLimits:  cfg_d.soil_limits      = pwdata[14:0];
        crc_pkg::RegPumpMinOff:  cfg_d.pump_min_off_sec = pwdata[22:0];
        crc_pkg::RegPumpMaxOn:   cfg_d.pump_max_on_sec  = pwdata[22:0];
        crc_pkg::RegLightOneWin: cfg_d.light_one_window = pwdata[21:0];
        crc_pkg::RegLightTwoWin: cfg_d.light_two_window = pwdata[21:0];
        crc_pkg::RegModeFlags:   cfg_d.mode_flags       = pwdata[3:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fan_on_temp      <= 15'sd2800;
      cfg_q.fan_off_temp     <= 15'sd2600;
      cfg_q.soil_limits      <= 15'd11555;
      cfg_q.pump_min_off_sec <= 23'd300;
      cfg_q.pump_max_on_sec  <= 23'd30;
      cfg_q.light_one_window <= 22'd2458080;
      cfg_q.light_two_window <= 22'd2458080;
      cfg_q.mode_flags       <= 4'd12;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      crc_pkg::RegFanOnTemp:   prdata = {17'd0, cfg_q.fan_on_temp};
      crc_pkg::RegFanOffTemp:  prdata = {17'd0, cfg_q.fan_off_temp};
      crc_pkg::RegSoilLimits:  prdata = {17'd0, cfg_q.soil_limits};
      crc_pkg::RegPumpMinOff:  prdata = {9'd0, cfg_q.pump_min_off_sec};
      crc_pkg::RegPumpMaxOn:   prdata = {9'd0, cfg_q.pump_max_on_sec};
      crc_pkg::RegLightOneWin: prdata = {10'd0, cfg_q.light_one_window};
      crc_pkg::RegLightTwoWin: prdata = {10'd0, cfg_q.light_two_window};
      crc_pkg::RegModeFlags:   prdata = {28'd0, cfg_q.mode_flags};
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/crc_ctrl.sv]
`timescale 1ns / 1ps
module crc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crc_pkg::crc_cfg_t     cfg_i,
  input  crc_pkg::crc_item_t    item_i,
  input  logic                  fire_i,
  output crc_pkg::crc_result_t  result_o
);

  logic        light_one_q, light_one_d;
  logic        light_two_q, light_two_d;
  logic        fan_q, fan_d;
  logic        pump_q, pump_d;
  logic [31:0] pump_start_q, pump_start_d;
  logic [31:0] pump_stop_q, pump_stop_d;

  logic [6:0]  s1_pct;
  logic [6:0]  s2_pct;
  logic [6:0]  dry_th;
  logic [6:0]  wet_th;
  logic        too_dry;
  logic        wet_enough;
  logic [31:0] min_off_ms;
  logic [31:0] max_on_ms;
  logic [31:0] off_elapsed;
  logic [31:0] on_elapsed;

  assign s1_pct     = crc_pkg::soil_pct(item_i.soil_one_raw);
  assign s2_pct     = crc_pkg::soil_pct(item_i.soil_two_raw);
  assign dry_th     = cfg_i.soil_limits[6:0];
  assign wet_th     = cfg_i.soil_limits[14:8];
  assign too_dry    = (s1_pct < dry_th) || (s2_pct < dry_th);
  assign wet_enough = (s1_pct > wet_th) && (s2_pct > wet_th);

  // seconds to ms, wrapping modulo 2^32
  assign min_off_ms  = 32'({9'd0, cfg_i.pump_min_off_sec} * 32'(crc_pkg::MsPerSec));
  assign max_on_ms   = 32'({9'd0, cfg_i.pump_max_on_sec} * 32'(crc_pkg::MsPerSec));
  assign off_elapsed = item_i.now_ms - pump_stop_q;
  assign on_elapsed  = item_i.now_ms - pump_start_q;

  always_comb begin
    light_one_d  = light_one_q;
    light_two_d  = light_two_q;
    fan_d        = fan_q;
    pump_d       = pump_q;
    pump_start_d = pump_start_q;
    pump_stop_d  = pump_stop_q;

    if (item_i.time_valid) begin
      if (cfg_i.mode_flags[crc_pkg::ModeLightOne]) begin
        light_one_d = crc_pkg::window_on(cfg_i.light_one_window, item_i.minute_of_day);
      end
      if (cfg_i.mode_flags[crc_pkg::ModeLightTwo]) begin
        light_two_d = crc_pkg::window_on(cfg_i.light_two_window, item_i.minute_of_day);
      end
    end

    if (cfg_i.mode_flags[crc_pkg::ModeAutoFan] && item_i.temp_valid) begin
      if (!fan_q && (item_i.temperature >= cfg_i.fan_on_temp)) begin
        fan_d = 1'b1;
      end else if (fan_q && (item_i.temperature <= cfg_i.fan_off_temp)) begin
        fan_d = 1'b0;
      end
    end

    if (cfg_i.mode_flags[crc_pkg::ModeAutoPump]) begin
      if (!pump_q) begin
        if (too_dry && (off_elapsed > min_off_ms)) begin
          pump_d       = 1'b1;
          pump_start_d = item_i.now_ms;
        end
      end else if (wet_enough || (on_elapsed > max_on_ms)) begin
        pump_d      = 1'b0;
        pump_stop_d = item_i.now_ms;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_one_q  <= 1'b0;
      light_two_q  <= 1'b0;
      fan_q        <= 1'b0;
      pump_q       <= 1'b0;
      pump_start_q <= '0;
      pump_stop_q  <= '0;
    end else if (fire_i) begin
      light_one_q  <= light_one_d;
      light_two_q  <= light_two_d;
      fan_q        <= fan_d;
      pump_q       <= pump_d;
      pump_start_q <= pump_start_d;
      pump_stop_q  <= pump_stop_d;
    end
  end

  assign result_o.light_one_on     = light_one_d;
  assign result_o.light_two_on     = light_two_d;
  assign result_o.fan_on           = fan_d;
  assign result_o.pump_on          = pump_d;
  assign result_o.soil_one_percent = s1_pct;
  assign result_o.soil_two_percent = s2_pct;

  a_pump_holds_manual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !cfg_i.mode_flags[crc_pkg::ModeAutoPump]
    |=> $stable(pump_q) && $stable(pump_start_q) && $stable(pump_stop_q))
    else $error("pump state moved while automatic pump is off");

  a_fan_holds_manual: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (!cfg_i.mode_flags[crc_pkg::ModeAutoFan] || !item_i.temp_valid)
    |=> $stable(fan_q))
    else $error("fan state moved without a valid automatic pass");

  a_pump_start_stamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pump_q) |-> (pump_start_q == $past(item_i.now_ms)) && $past(fire_i))
    else $error("pump start not stamped with the pass time");

endmodule

[rtl/core/climate_relay_controller.sv]
`timescale 1ns / 1ps
// an input transfer goes to the input register; its result is then written to
// the result register from one pass of control logic, once that register is free
// throughput: one item per cycle while m_axis_tready does not stall results
// reset: asynchronous, active low; clears relay states, pump times, valid flags
// and loads the default configuration
module climate_relay_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // apb configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crc_pkg::AddrW-1:0]      paddr,
  input  logic [crc_pkg::DataW-1:0]      pwdata,
  output logic [crc_pkg::DataW-1:0]      prdata,
  output logic                           pready,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // now_ms[31:0], minute_of_day[42:32], temperature[57:43],
  // soil_one_raw[69:58], soil_two_raw[81:70], zero pad[87:82]
  input  logic [crc_pkg::InDataW-1:0]    s_axis_tdata,
  // time_valid[0], temp_valid[1]
  input  logic [crc_pkg::InUserW-1:0]    s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // light_one_on[0], light_two_on[1], fan_on[2], pump_on[3],
  // soil_one_percent[10:4], soil_two_percent[17:11], zero pad[23:18]
  output logic [crc_pkg::OutDataW-1:0]   m_axis_tdata
);

  crc_pkg::crc_cfg_t    cfg;
  crc_pkg::crc_item_t   in_item;
  crc_pkg::crc_item_t   item_q;
  crc_pkg::crc_result_t result;
  crc_pkg::crc_result_t res_q;

  logic item_vld_q, item_vld_d;
  logic res_vld_q, res_vld_d;
  logic res_free;
  logic pass_fire;
  logic in_fire;

  assign pready = 1'b1;

  crc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  assign in_item.now_ms        = s_axis_tdata[31:0];
  assign in_item.time_valid    = s_axis_tuser[0];
  assign in_item.minute_of_day = s_axis_tdata[42:32];
  assign in_item.temp_valid    = s_axis_tuser[1];
  assign in_item.temperature   = $signed(s_axis_tdata[57:43]);
  assign in_item.soil_one_raw  = s_axis_tdata[69:58];
  assign in_item.soil_two_raw  = s_axis_tdata[81:70];

  assign res_free      = !res_vld_q || m_axis_tready;
  assign pass_fire     = item_vld_q && res_free;
  assign s_axis_tready = !item_vld_q || res_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    item_vld_d = item_vld_q;
    if (in_fire) begin
      item_vld_d = 1'b1;
    end else if (pass_fire) begin
      item_vld_d = 1'b0;
    end
    res_vld_d = res_vld_q;
    if (pass_fire) begin
      res_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      res_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      item_vld_q <= item_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item;
    end
    if (pass_fire) begin
      res_q <= result;
    end
  end

  crc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .item_i   (item_q),
    .fire_i   (pass_fire),
    .result_o (result)
  );

  assign m_axis_tvalid = res_vld_q;
  assign m_axis_tdata  = {6'd0, res_q.soil_two_percent, res_q.soil_one_percent,
                          res_q.pump_on, res_q.fan_on, res_q.light_two_on,
                          res_q.light_one_on};

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res_q.soil_one_percent <= 7'(crc_pkg::PctFull)) &&
                      (res_q.soil_two_percent <= 7'(crc_pkg::PctFull)))
    else $error("soil percent above full scale");

  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> item_vld_q && res_vld_q && !m_axis_tready)
    else $error("input held off without a stalled result");

endmodule

[tb/sv/climate_relay_controller_tb.sv]
`timescale 1ns / 1ps
module climate_relay_controller_tb;

  typedef struct {
    bit                   is_cfg;
    crc_pkg::crc_reg_e    addr;
    logic [31:0]          wdata;
    crc_pkg::crc_item_t   item;
    bit                   chk;
    crc_pkg::crc_result_t res;
  } stim_row_t;

  typedef struct {
    bit                   chk;
    crc_pkg::crc_result_t res;
  } offer_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic                         psel          = 1'b0;
  logic                         penable       = 1'b0;
  logic                         pwrite        = 1'b0;
  logic [crc_pkg::AddrW-1:0]    paddr         = '0;
  logic [crc_pkg::DataW-1:0]    pwdata        = '0;
  logic [crc_pkg::DataW-1:0]    prdata;
  logic                         pready;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [crc_pkg::InDataW-1:0]  s_axis_tdata  = '0;
  logic [crc_pkg::InUserW-1:0]  s_axis_tuser  = '0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [crc_pkg::OutDataW-1:0] m_axis_tdata;

  // shadow of the block: configuration and relay state
  crc_pkg::crc_cfg_t cfg_model;
  logic              light_one_st, light_two_st, fan_st, pump_st;
  logic [31:0]       pump_t_start, pump_t_stop;

  offer_t               offered_q[$];
  crc_pkg::crc_result_t out_due_q[$];
  stim_row_t            stim_tab[$];

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_req  = 0;
  int unsigned sink_hold_left = 0;
  int unsigned errors         = 0;
  int unsigned items_in       = 0;
  int unsigned results_seen   = 0;
  int unsigned reg_writes     = 0;

  always #2 clk_i = ~clk_i;

  climate_relay_controller uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  function automatic logic [10:0] fold_minute(input logic [10:0] m);
    return (m >= 11'(crc_pkg::MinPerDay)) ? m - 11'(crc_pkg::MinPerDay) : m;
  endfunction

  // daily window, may cross midnight; equal on and off means off
  function automatic logic sched_lit(input logic [21:0] win, input logic [10:0] minute);
    logic [10:0] t_on;
    logic [10:0] t_off;
    logic [10:0] t_now;
    t_on  = fold_minute(win[10:0]);
    t_off = fold_minute(win[21:11]);
    t_now = fold_minute(minute);
    if (t_on == t_off) return 1'b0;
    if (t_on < t_off) return (t_now >= t_on) && (t_now < t_off);
    return (t_now >= t_on) || (t_now < t_off);
  endfunction

  function automatic logic [6:0] moisture(input logic [11:0] raw);
    int r;
    r = raw;
    return 7'(100 - (100 * r) / 4095);
  endfunction

  function automatic crc_pkg::crc_result_t control_pass(input crc_pkg::crc_item_t it);
    crc_pkg::crc_result_t r;
    logic [6:0]  s1, s2, dry, wet;
    logic        too_dry, soaked;
    logic [31:0] off_ms, on_ms;
    s1 = moisture(it.soil_one_raw);
    s2 = moisture(it.soil_two_raw);
    if (it.time_valid) begin
      if (cfg_model.mode_flags[crc_pkg::ModeLightOne])
        light_one_st = sched_lit(cfg_model.light_one_window, it.minute_of_day);
      if (cfg_model.mode_flags[crc_pkg::ModeLightTwo])
        light_two_st = sched_lit(cfg_model.light_two_window, it.minute_of_day);
    end
    if (cfg_model.mode_flags[crc_pkg::ModeAutoFan] && it.temp_valid) begin
      if (!fan_st && $signed(it.temperature) >= $signed(cfg_model.fan_on_temp))
        fan_st = 1'b1;
      else if (fan_st && $signed(it.temperature) <= $signed(cfg_model.fan_off_temp))
        fan_st = 1'b0;
    end
    if (cfg_model.mode_flags[crc_pkg::ModeAutoPump]) begin
      dry     = cfg_model.soil_limits[6:0];
      wet     = cfg_model.soil_limits[14:8];
      too_dry = (s1 < dry) || (s2 < dry);
      soaked  = (s1 > wet) && (s2 > wet);
      // second counts scaled to ms wrap at 32 bits, as do the elapsed times
      off_ms  = cfg_model.pump_min_off_sec * 32'd1000;
      on_ms   = cfg_model.pump_max_on_sec * 32'd1000;
      if (!pump_st) begin
        if (too_dry && (it.now_ms - pump_t_stop) > off_ms) begin
          pump_st      = 1'b1;
          pump_t_start = it.now_ms;
        end
      end else if (soaked || (it.now_ms - pump_t_start) > on_ms) begin
        pump_st     = 1'b0;
        pump_t_stop = it.now_ms;
      end
    end
    r.light_one_on     = light_one_st;
    r.light_two_on     = light_two_st;
    r.fan_on           = fan_st;
    r.pump_on          = pump_st;
    r.soil_one_percent = s1;
    r.soil_two_percent = s2;
    return r;
  endfunction

  function automatic stim_row_t row_cfg(input crc_pkg::crc_reg_e addr, input logic [31:0] v);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.addr   = addr;
    r.wdata  = v;
    r.item   = '0;
    r.chk    = 1'b0;
    r.res    = '0;
    return r;
  endfunction

  function automatic stim_row_t row_item(input logic [31:0] now, input bit tv,
                                         input logic [10:0] mn, input bit pv,
                                         input logic signed [14:0] tp,
                                         input logic [11:0] r1, input logic [11:0] r2,
                                         input bit chk, input logic [17:0] res);
    stim_row_t r;
    r.is_cfg             = 1'b0;
    r.addr               = crc_pkg::RegModeFlags;
    r.wdata              = '0;
    r.item.now_ms        = now;
    r.item.time_valid    = tv;
    r.item.minute_of_day = mn;
    r.item.temp_valid    = pv;
    r.item.temperature   = tp;
    r.item.soil_one_raw  = r1;
    r.item.soil_two_raw  = r2;
    r.chk                = chk;
    r.res                = res;
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  task automatic send_item(input crc_pkg::crc_item_t it, input bit chk,
                           input crc_pkg::crc_result_t res);
    offer_t o;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, it.soil_two_raw, it.soil_one_raw, it.temperature,
                      it.minute_of_day, it.now_ms};
    s_axis_tuser  <= {it.temp_valid, it.time_valid};
    o.chk = chk;
    o.res = res;
    offered_q.push_back(o);
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold the input side until every result is back, then let the pipe empty
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (offered_q.size() != 0 || out_due_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write, then read back through the same port
  task automatic cfg_write(input crc_pkg::crc_reg_e r, input logic [31:0] v);
    logic [31:0] m;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (r)
      crc_pkg::RegFanOnTemp: begin
        m = 32'h7FFF;
        cfg_model.fan_on_temp = v[14:0];
      end
      crc_pkg::RegFanOffTemp: begin
        m = 32'h7FFF;
        cfg_model.fan_off_temp = v[14:0];
      end
      crc_pkg::RegSoilLimits: begin
        m = 32'h7FFF;
        cfg_model.soil_limits = v[14:0];
      end
      crc_pkg::RegPumpMinOff: begin
        m = 32'h7F_FFFF;
        cfg_model.pump_min_off_sec = v[22:0];
      end
      crc_pkg::RegPumpMaxOn: begin
        m = 32'h7F_FFFF;
        cfg_model.pump_max_on_sec = v[22:0];
      end
      crc_pkg::RegLightOneWin: begin
        m = 32'h3F_FFFF;
        cfg_model.light_one_window = v[21:0];
      end
      crc_pkg::RegLightTwoWin: begin
        m = 32'h3F_FFFF;
        cfg_model.light_two_window = v[21:0];
      end
      default: begin
        m = 32'hF;
        cfg_model.mode_flags = v[3:0];
      end
    endcase
    if ((prdata & m) != (v & m)) begin
      errors++;
      $display("%0t: register %s readback, expected %h actual %h", $time, r.name(),
               v & m, prdata & m);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    reg_writes++;
  endtask

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk_i) begin
    if (sink_hold_req != 0) begin
      sink_hold_left = sink_hold_req;
      sink_hold_req  = 0;
    end
    if (sink_hold_left != 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // input transfer: run the shadow model and queue what should come out
  always @(posedge clk_i) begin : take_in
    crc_pkg::crc_item_t   it;
    crc_pkg::crc_result_t p;
    offer_t               o;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      it.now_ms        = s_axis_tdata[31:0];
      it.minute_of_day = s_axis_tdata[42:32];
      it.temperature   = s_axis_tdata[57:43];
      it.soil_one_raw  = s_axis_tdata[69:58];
      it.soil_two_raw  = s_axis_tdata[81:70];
      it.time_valid    = s_axis_tuser[0];
      it.temp_valid    = s_axis_tuser[1];
      p = control_pass(it);
      o = offered_q.pop_front();
      out_due_q.push_back(o.chk ? o.res : p);
      items_in++;
    end
  end

  always @(posedge clk_i) begin : take_out
    crc_pkg::crc_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (out_due_q.size() == 0) begin
        errors++;
        $display("%0t: result %h with nothing expected, expected none actual %h",
                 $time, m_axis_tdata, m_axis_tdata);
      end else begin
        want = out_due_q.pop_front();
        check_field("light_one_on", want.light_one_on, m_axis_tdata[0]);
        check_field("light_two_on", want.light_two_on, m_axis_tdata[1]);
        check_field("fan_on", want.fan_on, m_axis_tdata[2]);
        check_field("pump_on", want.pump_on, m_axis_tdata[3]);
        check_field("soil_one_percent", want.soil_one_percent, m_axis_tdata[10:4]);
        check_field("soil_two_percent", want.soil_two_percent, m_axis_tdata[17:11]);
      end
    end
  end

  initial begin : main
    int unsigned        src_mix[4];
    int unsigned        sink_mix[4];
    logic [31:0]        clk_ms;
    crc_pkg::crc_item_t it;
    int                 t_on, t_off, dry;
    logic [3:0]         mode;

    src_mix  = '{0, 60, 0, 15};
    sink_mix = '{0, 0, 60, 15};

    cfg_model.fan_on_temp      = 15'sd2800;
    cfg_model.fan_off_temp     = 15'sd2600;
    cfg_model.soil_limits      = 15'd11555;
    cfg_model.pump_min_off_sec = 23'd300;
    cfg_model.pump_max_on_sec  = 23'd30;
    cfg_model.light_one_window = 22'd2458080;
    cfg_model.light_two_window = 22'd2458080;
    cfg_model.mode_flags       = 4'd12;
    light_one_st = 1'b0;
    light_two_st = 1'b0;
    fan_st       = 1'b0;
    pump_st      = 1'b0;
    pump_t_start = '0;
    pump_t_stop  = '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: lights manual, fan and pump automatic, dry 35 wet 45
    // relays listed as {light one, light two, fan, pump}
    stim_tab.push_back(row_item(0, 0, 0, 0, 0, 0, 0, 1, {4'b0000, 7'd100, 7'd100}));
    stim_tab.push_back(row_item(0, 0, 0, 0, 0, 12'hFFF, 12'hFFF, 1,
                                {4'b0000, 7'd0, 7'd0}));
    stim_tab.push_back(row_item(5, 1, 1439, 1, 13000, 0, 0, 1, {4'b0010, 7'd100, 7'd100}));
    stim_tab.push_back(row_item(10, 1, 0, 1, -4500, 0, 0, 1, {4'b0000, 7'd100, 7'd100}));
    // pump starts one ms after the minimum off time
    stim_tab.push_back(row_item(300001, 0, 0, 0, 0, 12'hFFF, 0, 1, {4'b0001, 7'd0, 7'd100}));
    // exactly the maximum on time keeps it running, one ms more stops it
    stim_tab.push_back(row_item(330001, 0, 0, 0, 0, 12'hFFF, 12'hFFF, 1,
                                {4'b0001, 7'd0, 7'd0}));
    stim_tab.push_back(row_item(330002, 0, 0, 0, 0, 12'hFFF, 12'hFFF, 1,
                                {4'b0000, 7'd0, 7'd0}));
    stim_tab.push_back(row_item(630002, 0, 0, 0, 0, 12'hFFF, 12'hFFF, 1,
                                {4'b0000, 7'd0, 7'd0}));
    // fan hysteresis edges
    stim_tab.push_back(row_item(630003, 0, 0, 1, 2800, 0, 0, 1, {4'b0010, 7'd100, 7'd100}));
    stim_tab.push_back(row_item(630004, 0, 0, 1, 2601, 0, 0, 1, {4'b0010, 7'd100, 7'd100}));
    stim_tab.push_back(row_item(630005, 0, 0, 1, 2600, 0, 0, 1, {4'b0000, 7'd100, 7'd100}));
    stim_tab.push_back(row_item(630010, 0, 0, 0, 0, 2048, 41, 0, '0));
    stim_tab.push_back(row_item(630011, 0, 0, 0, 0, 40, 4094, 0, '0));
    // window across midnight on light one, equal on and off on light two
    stim_tab.push_back(row_cfg(crc_pkg::RegModeFlags, 32'hF));
    stim_tab.push_back(row_cfg(crc_pkg::RegLightOneWin, (32'd60 << 11) | 32'd1439));
    stim_tab.push_back(row_cfg(crc_pkg::RegLightTwoWin, (32'd500 << 11) | 32'd500));
    stim_tab.push_back(row_item(700000, 1, 1439, 0, 0, 0, 0, 0, '0));
    stim_tab.push_back(row_item(700001, 1, 59, 0, 0, 0, 0, 0, '0));
    stim_tab.push_back(row_item(700002, 1, 60, 0, 0, 0, 0, 0, '0));
    stim_tab.push_back(row_item(700003, 1, 1440, 0, 0, 0, 0, 0, '0));
    stim_tab.push_back(row_item(700004, 1, 2047, 0, 0, 0, 0, 0, '0));
    stim_tab.push_back(row_item(700005, 0, 100, 0, 0, 0, 0, 0, '0));
    // register extremes
    stim_tab.push_back(row_cfg(crc_pkg::RegFanOnTemp, 32'(-4000)));
    stim_tab.push_back(row_cfg(crc_pkg::RegFanOffTemp, 32'd12500));
    stim_tab.push_back(row_cfg(crc_pkg::RegSoilLimits, 32'h7F7F));
    stim_tab.push_back(row_cfg(crc_pkg::RegPumpMinOff, 32'd0));
    stim_tab.push_back(row_cfg(crc_pkg::RegPumpMaxOn, 32'd4294967));
    stim_tab.push_back(row_cfg(crc_pkg::RegLightOneWin, 32'h3F_FFFF));
    stim_tab.push_back(row_cfg(crc_pkg::RegLightTwoWin, 32'h3F_FFFF));
    stim_tab.push_back(row_item(800000, 1, 700, 1, 13000, 2000, 2000, 0, '0));
    stim_tab.push_back(row_item(32'hFFFF_FFFF, 1, 1000, 1, 12500, 4095, 0, 0, '0));
    stim_tab.push_back(row_item(3, 1, 1439, 1, -16384, 0, 0, 0, '0));
    stim_tab.push_back(row_cfg(crc_pkg::RegModeFlags, 32'h0));
    stim_tab.push_back(row_item(5000, 1, 480, 1, 16383, 12'hFFF, 12'hFFF, 0, '0));

    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg) begin
        settle();
        cfg_write(stim_tab[i].addr, stim_tab[i].wdata);
      end else begin
        send_item(stim_tab[i].item, stim_tab[i].chk, stim_tab[i].res);
      end
    end

    clk_ms = 32'd900000;
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      src_idle_pct   = src_mix[ph];
      sink_stall_pct = sink_mix[ph];
      t_on = $urandom_range(0, 16500) - 4000;
      cfg_write(crc_pkg::RegFanOnTemp, ($urandom_range(3) == 0) ? $urandom() : 32'(t_on));
      cfg_write(crc_pkg::RegFanOffTemp, 32'(t_on - int'($urandom_range(0, 800))));
      dry = $urandom_range(0, 100);
      cfg_write(crc_pkg::RegSoilLimits, ($urandom_range(4) == 0) ? $urandom() :
                32'((int'($urandom_range(dry, 100)) << 8) | dry));
      cfg_write(crc_pkg::RegPumpMinOff, ($urandom_range(5) == 0) ? $urandom() :
                32'($urandom_range(0, 5)));
      cfg_write(crc_pkg::RegPumpMaxOn, ($urandom_range(5) == 0) ? $urandom() :
                32'($urandom_range(0, 8)));
      t_on  = $urandom_range(0, 1439);
      t_off = ($urandom_range(4) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1439);
      cfg_write(crc_pkg::RegLightOneWin, 32'((t_off << 11) | t_on));
      t_on  = ($urandom_range(4) == 0) ? $urandom_range(1440, 2047) : $urandom_range(0, 1439);
      t_off = $urandom_range(0, 1439);
      cfg_write(crc_pkg::RegLightTwoWin, 32'((t_off << 11) | t_on));
      mode = 4'($urandom_range(15));
      if ($urandom_range(3) != 0) mode = mode | 4'b1100;
      cfg_write(crc_pkg::RegModeFlags, 32'(mode));

      // long receiver hold-off while the sender keeps offering
      if (ph == 0) sink_hold_req = 400;
      for (int n = 0; n < 250; n++) begin
        if (ph == 1 && n == 125) settle();
        case ($urandom_range(19))
          0:       clk_ms = $urandom();
          1:       clk_ms = clk_ms + $urandom_range(0, 400000);
          default: clk_ms = clk_ms + $urandom_range(0, 2500);
        endcase
        it.now_ms        = clk_ms;
        it.time_valid    = ($urandom_range(9) != 0);
        it.minute_of_day = ($urandom_range(9) == 0) ? 11'($urandom_range(1440, 2047)) :
                                                      11'($urandom_range(0, 1439));
        it.temp_valid    = ($urandom_range(9) != 0);
        it.temperature   = ($urandom_range(9) == 0) ? 15'($urandom()) :
                                                      15'(int'($urandom_range(0, 17500)) - 4500);
        it.soil_one_raw  = 12'($urandom());
        it.soil_two_raw  = 12'($urandom());
        send_item(it, 1'b0, '0);
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (out_due_q.size() != 0) begin
      errors++;
      $display("%0t: results missing, expected %0d more actual 0", $time,
               out_due_q.size());
    end
    $display("run covered %0d control passes in and %0d results checked,", items_in,
             results_seen);
    $display("with %0d register writes and four handshake mixes", reg_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

[climate_relay_controller.f]
rtl/core/crc_pkg.sv
rtl/core/crc_cfg_regs.sv
rtl/core/crc_ctrl.sv
rtl/core/climate_relay_controller.sv
tb/sv/climate_relay_controller_tb.sv
